FILE: rtl/core/cbmt_pkg.sv
// ----------------------------------------------------------------------------
// cbmt_pkg
// Shared types and constants for the counter bank with maximum tracking.
// ----------------------------------------------------------------------------
package cbmt_pkg;

    localparam int COUNTERS_DEF   = 64;
    localparam int COUNT_BITS_DEF = 16;

    localparam int OP_W        = 2;
    localparam int IDX_W       = 6;
    localparam int VAL_W       = 16;
    localparam int HOLD_W      = 7;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_INC   = 2'd0,
        OP_DEC   = 2'd1,
        OP_CLR   = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_DONE = 2'd2
    } t_state;

    // update command for one cell: the op is shared by every cell, the enable is set only for the addressed one
    typedef struct packed {
        logic en;
        t_op  op;
    } t_cmd;

endpackage

FILE: rtl/core/cbmt_cell.sv
// ----------------------------------------------------------------------------
// cbmt_cell
// One counter of the bank plus one registered stage of the max/holder scan.
// ----------------------------------------------------------------------------
module cbmt_cell #(
    parameter int COUNT_BITS = cbmt_pkg::COUNT_BITS_DEF,
    parameter int CNT_W      = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cbmt_pkg::t_cmd               i_cmd,
    input  logic                         i_first,
    input  logic signed [COUNT_BITS-1:0] i_prev_best,
    input  logic        [CNT_W-1:0]      i_prev_n,
    output logic signed [COUNT_BITS-1:0] o_count,
    output logic signed [COUNT_BITS-1:0] o_best,
    output logic        [CNT_W-1:0]      o_n
);

    localparam logic signed [COUNT_BITS-1:0] MAXV = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] MINV = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic signed [COUNT_BITS-1:0] r_count, n_count;
    logic signed [COUNT_BITS-1:0] r_best, n_best;
    logic        [CNT_W-1:0]      r_n, n_n;

    always_comb begin
        n_count = r_count;
        if (i_cmd.en) begin
            case (i_cmd.op)
                cbmt_pkg::OP_INC: begin
                    if (r_count != MAXV) n_count = r_count + COUNT_BITS'(1);
                end
                cbmt_pkg::OP_DEC: begin
                    if (r_count != MINV) n_count = r_count - COUNT_BITS'(1);
                end
                cbmt_pkg::OP_CLR:   n_count = '0;
                cbmt_pkg::OP_QUERY: n_count = r_count;
                default:            n_count = r_count;
            endcase
        end
    end

    // running max and holder count, passed one cell per cycle
    always_comb begin
        if (i_first || r_count > i_prev_best) begin
            n_best = r_count;
            n_n    = CNT_W'(1);
        end else if (r_count == i_prev_best) begin
            n_best = i_prev_best;
            n_n    = i_prev_n + CNT_W'(1);
        end else begin
            n_best = i_prev_best;
            n_n    = i_prev_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        r_n    <= n_n;
    end

    assign o_count = r_count;
    assign o_best  = r_best;
    assign o_n     = r_n;

endmodule

FILE: rtl/core/counter_bank_max_tracker.sv
// ----------------------------------------------------------------------------
// counter_bank_max_tracker
// Bank of saturating signed counters that reports the addressed counter,
// the bank maximum and the number of counters holding it.
// ----------------------------------------------------------------------------
// flow: an accepted beat is scanned through the registered row of cells,
//   which walks one counter per cycle, then loads the output register; an
//   index beyond the bank skips the scan and goes straight to the output
// input: no new beat is taken until the result of the last one is loaded
// reset: synchronous, clears every counter, max to zero, holders to COUNTERS
module counter_bank_max_tracker #(
    parameter int COUNTERS   = cbmt_pkg::COUNTERS_DEF,
    parameter int COUNT_BITS = cbmt_pkg::COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [1:0] operation, [7:2] counter_index
    input  logic [cbmt_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] counter_value, [31:16] max_value, [38:32] max_holders, [39] zero
    output logic [cbmt_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int CNT_W  = $clog2(COUNTERS + 1) < 1 ? 1 : $clog2(COUNTERS + 1);
    localparam int EXT_W  = COUNT_BITS > cbmt_pkg::VAL_W ? COUNT_BITS : cbmt_pkg::VAL_W;
    localparam int HEXT_W = CNT_W > cbmt_pkg::HOLD_W ? CNT_W : cbmt_pkg::HOLD_W;

    cbmt_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0]                   r_scan, n_scan;
    logic [cbmt_pkg::IDX_W-1:0]         r_idx;
    logic                               r_oor;
    logic signed [COUNT_BITS-1:0]       r_max;
    logic [CNT_W-1:0]                   r_hold;
    logic                               r_out_valid;
    logic [cbmt_pkg::VAL_W-1:0]         r_cv, r_mv;
    logic [cbmt_pkg::HOLD_W-1:0]        r_mh;

    logic                               in_acc;
    logic                               load_out;
    cbmt_pkg::t_op                      in_op;
    logic [cbmt_pkg::IDX_W-1:0]         in_idx;
    logic                               in_range;

    logic signed [COUNT_BITS-1:0]       counts [COUNTERS];
    logic signed [COUNT_BITS-1:0]       bests  [COUNTERS];
    logic [CNT_W-1:0]                   ns     [COUNTERS];
    logic signed [COUNT_BITS-1:0]       sel_count;

    logic signed [COUNT_BITS-1:0]       res_val, res_max;
    logic [CNT_W-1:0]                   res_hold;
    logic signed [EXT_W-1:0]            ext_val, ext_max;
    logic [HEXT_W-1:0]                  ext_hold;

    assign in_op    = cbmt_pkg::t_op'(i_s_axis_tdata[1:0]);
    assign in_idx   = i_s_axis_tdata[7:2];
    assign in_range = 32'(in_idx) < COUNTERS;
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    genvar k;
    generate
        for (k = 0; k < COUNTERS; k++) begin : g_cell
            cbmt_pkg::t_cmd cmd;
            assign cmd.en = in_acc && (32'(in_idx) == k);
            assign cmd.op = in_op;
            if (k == 0) begin : g_head
                cbmt_cell #(
                    .COUNT_BITS (COUNT_BITS),
                    .CNT_W      (CNT_W)
                ) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_cmd       (cmd),
                    .i_first     (1'b1),
                    .i_prev_best ('0),
                    .i_prev_n    ('0),
                    .o_count     (counts[k]),
                    .o_best      (bests[k]),
                    .o_n         (ns[k])
                );
            end else begin : g_body
                cbmt_cell #(
                    .COUNT_BITS (COUNT_BITS),
                    .CNT_W      (CNT_W)
                ) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_cmd       (cmd),
                    .i_first     (1'b0),
                    .i_prev_best (bests[k-1]),
                    .i_prev_n    (ns[k-1]),
                    .o_count     (counts[k]),
                    .o_best      (bests[k]),
                    .o_n         (ns[k])
                );
            end
        end
    endgenerate

    always_comb begin
        sel_count = '0;
        for (int j = 0; j < COUNTERS; j++) begin
            if (32'(r_idx) == j) sel_count = counts[j];
        end
    end

    always_comb begin
        n_state         = r_state;
        n_scan          = r_scan;
        o_s_axis_tready = 1'b0;
        load_out        = 1'b0;
        case (r_state)
            cbmt_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_scan  = '0;
                    n_state = in_range ? cbmt_pkg::ST_SCAN : cbmt_pkg::ST_DONE;
                end
            end
            cbmt_pkg::ST_SCAN: begin
                // last cell holds the full scan once every stage has refilled
                n_scan = r_scan + CNT_W'(1);
                if (32'(r_scan) == COUNTERS - 1) n_state = cbmt_pkg::ST_DONE;
            end
            cbmt_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = cbmt_pkg::ST_IDLE;
                end
            end
            default: n_state = cbmt_pkg::ST_IDLE;
        endcase
    end

    assign res_val  = r_oor ? '0 : sel_count;
    assign res_max  = r_oor ? r_max : bests[COUNTERS-1];
    assign res_hold = r_oor ? r_hold : ns[COUNTERS-1];
    assign ext_val  = EXT_W'(res_val);
    assign ext_max  = EXT_W'(res_max);
    assign ext_hold = HEXT_W'(res_hold);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cbmt_pkg::ST_IDLE;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
            r_max       <= '0;
            r_hold      <= CNT_W'(COUNTERS);
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_max       <= res_max;
                r_hold      <= res_hold;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_idx <= in_idx;
            r_oor <= !in_range;
        end
        if (load_out) begin
            r_cv <= ext_val[cbmt_pkg::VAL_W-1:0];
            r_mv <= ext_max[cbmt_pkg::VAL_W-1:0];
            r_mh <= ext_hold[cbmt_pkg::HOLD_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_mh, r_mv, r_cv};

endmodule

FILE: verif/counter_bank_max_tracker_tb.sv
// ----------------------------------------------------------------------------
// counter_bank_max_tracker_tb
// Self-checking bench for the saturating counter bank with max tracking.
// Beats from a stimulus queue are driven with random gaps. A local copy of
// the bank predicts the counter value, the bank maximum and the holder count
// for every accepted beat. A monitor with random back-pressure and long
// stalls checks each result in order against those predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module counter_bank_max_tracker_tb;

    localparam int BANK_SIZE = cbmt_pkg::COUNTERS_DEF;
    localparam logic signed [cbmt_pkg::VAL_W-1:0] CNT_HI = {1'b0, {(cbmt_pkg::VAL_W-1){1'b1}}};
    localparam logic signed [cbmt_pkg::VAL_W-1:0] CNT_LO = {1'b1, {(cbmt_pkg::VAL_W-1){1'b0}}};
    localparam int STIM_TARGET = 1700;

    typedef struct packed {
        logic signed [cbmt_pkg::VAL_W-1:0] counter_value;
        logic signed [cbmt_pkg::VAL_W-1:0] max_value;
        logic [cbmt_pkg::HOLD_W-1:0]       max_holders;
    } t_report;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [cbmt_pkg::IN_TDATA_W-1:0]  s_data = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [cbmt_pkg::OUT_TDATA_W-1:0] m_data;

    // local copy of the bank
    logic signed [cbmt_pkg::VAL_W-1:0] bank_count [BANK_SIZE];
    t_report                           expected_reports [$];
    logic [cbmt_pkg::IN_TDATA_W-1:0]   stim_beats [$];

    int total_beats = 0;
    int beats_in = 0;
    int results_seen = 0;
    int hold_left = 0;
    int errors = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int tx_calm = 0;
    int rx_calm = 0;
    t_report want;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    counter_bank_max_tracker DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    // wait before the next beat, with occasional runs of back-to-back beats
    function automatic int next_gap(inout int calm);
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(20, 80);
        return $urandom_range(0, 19);
    endfunction

    function automatic void push_item(cbmt_pkg::t_op op, int idx);
        stim_beats.insert(stim_beats.size(), {idx[cbmt_pkg::IDX_W-1:0], op});
    endfunction

    // apply the op to one counter (a query changes nothing), then rescan the whole bank for max and holders
    function automatic void apply_to_bank(logic [cbmt_pkg::IN_TDATA_W-1:0] beat);
        cbmt_pkg::t_op                     op;
        int                                idx;
        int                                n;
        logic signed [cbmt_pkg::VAL_W-1:0] best;
        t_report                           r;
        op  = cbmt_pkg::t_op'(beat[cbmt_pkg::OP_W-1:0]);
        idx = beat[cbmt_pkg::OP_W +: cbmt_pkg::IDX_W];
        case (op)
            cbmt_pkg::OP_INC: begin
                if (bank_count[idx] != CNT_HI)
                    bank_count[idx] = bank_count[idx] + cbmt_pkg::VAL_W'(1);
            end
            cbmt_pkg::OP_DEC: begin
                if (bank_count[idx] != CNT_LO)
                    bank_count[idx] = bank_count[idx] - cbmt_pkg::VAL_W'(1);
            end
            cbmt_pkg::OP_CLR: begin
                bank_count[idx] = '0;
            end
            default: ;
        endcase
        best = bank_count[0];
        n = 0;
        for (int k = 0; k < BANK_SIZE; k++) begin
            if (bank_count[k] > best) begin
                best = bank_count[k];
                n = 1;
            end else if (bank_count[k] == best) begin
                n++;
            end
        end
        r.counter_value = bank_count[idx];
        r.max_value     = best;
        r.max_holders   = n[cbmt_pkg::HOLD_W-1:0];
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    function automatic cbmt_pkg::t_op pick_op(int bias);
        int            r;
        cbmt_pkg::t_op major;
        cbmt_pkg::t_op minor;
        r = $urandom_range(0, 15);
        major = (bias == 0) ? cbmt_pkg::OP_INC : cbmt_pkg::OP_DEC;
        minor = (bias == 0) ? cbmt_pkg::OP_DEC : cbmt_pkg::OP_INC;
        if (bias > 1) return cbmt_pkg::t_op'(r[1:0]);
        if (r < 10) return major;
        if (r < 13) return minor;
        if (r < 14) return cbmt_pkg::OP_CLR;
        return cbmt_pkg::OP_QUERY;
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else if (s_valid && s_ready) begin
            apply_to_bank(s_data);
            beats_in <= beats_in + 1;
            tx_gap = next_gap(tx_calm);
            if (tx_gap == 0 && stim_beats.size() > 0) begin
                s_data <= stim_beats.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end else if (!s_valid) begin
            if (tx_gap > 0) begin
                tx_gap = tx_gap - 1;
            end else if (stim_beats.size() > 0) begin
                s_valid <= 1'b1;
                s_data  <= stim_beats.pop_front();
            end
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        if (!rst_n) begin
            m_ready <= 1'b0;
            rx_gap = 0;
            results_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_reports.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                    errors++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("counter_value", want.counter_value,
                                $signed(m_data[cbmt_pkg::VAL_W-1:0]));
                    check_field("max_value", want.max_value,
                                $signed(m_data[2*cbmt_pkg::VAL_W-1:cbmt_pkg::VAL_W]));
                    check_field("max_holders", want.max_holders,
                                m_data[2*cbmt_pkg::VAL_W +: cbmt_pkg::HOLD_W]);
                end
                rx_gap = next_gap(rx_calm);
            end else if (rx_gap > 0) begin
                rx_gap = rx_gap - 1;
            end
            m_ready <= (rx_gap == 0) && (hold_left == 0);
        end
    end

    // long receiver stalls so the block backs up into its input
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (m_valid && m_ready && (results_seen == 400 || results_seen == 1100)) begin
            hold_left <= 600;
        end
    end

    initial begin
        int            hot [8];
        int            n_hot;
        int            len;
        int            bias;
        int            kind;
        cbmt_pkg::t_op op;

        for (int k = 0; k < BANK_SIZE; k++) bank_count[k] = '0;

        // directed: ties, sole holder dropping, negatives, all-equal bank
        push_item(cbmt_pkg::OP_QUERY, 0);
        push_item(cbmt_pkg::OP_INC, 0);
        push_item(cbmt_pkg::OP_INC, 63);
        push_item(cbmt_pkg::OP_INC, 63);
        push_item(cbmt_pkg::OP_DEC, 63);
        push_item(cbmt_pkg::OP_DEC, 0);
        push_item(cbmt_pkg::OP_DEC, 63);
        push_item(cbmt_pkg::OP_DEC, 42);
        push_item(cbmt_pkg::OP_DEC, 21);
        push_item(cbmt_pkg::OP_DEC, 21);
        push_item(cbmt_pkg::OP_CLR, 42);
        push_item(cbmt_pkg::OP_QUERY, 21);
        push_item(cbmt_pkg::OP_INC, 21);
        push_item(cbmt_pkg::OP_INC, 21);
        push_item(cbmt_pkg::OP_INC, 21);
        push_item(cbmt_pkg::OP_CLR, 21);
        push_item(cbmt_pkg::OP_INC, 42);
        push_item(cbmt_pkg::OP_INC, 42);
        push_item(cbmt_pkg::OP_DEC, 42);
        push_item(cbmt_pkg::OP_DEC, 42);
        push_item(cbmt_pkg::OP_DEC, 42);
        push_item(cbmt_pkg::OP_CLR, 42);
        push_item(cbmt_pkg::OP_QUERY, 63);

        // random: focused runs on a few counters, whole-bank sweeps, noise
        while (stim_beats.size() < STIM_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                n_hot = $urandom_range(1, 6);
                for (int h = 0; h < n_hot; h++) hot[h] = $urandom_range(0, BANK_SIZE - 1);
                bias = $urandom_range(0, 2);
                len = $urandom_range(20, 60);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0)
                        push_item(pick_op(bias), $urandom_range(0, BANK_SIZE - 1));
                    else
                        push_item(pick_op(bias), hot[$urandom_range(0, n_hot - 1)]);
                end
            end else if (kind < 8) begin
                op = cbmt_pkg::t_op'($urandom_range(0, 2));
                if ($urandom_range(0, 1) == 0)
                    for (int i = 0; i < BANK_SIZE; i++) push_item(op, i);
                else
                    for (int i = BANK_SIZE - 1; i >= 0; i--) push_item(op, i);
            end else begin
                len = $urandom_range(10, 30);
                for (int i = 0; i < len; i++)
                    push_item(cbmt_pkg::t_op'($urandom_range(0, 3)),
                              $urandom_range(0, BANK_SIZE - 1));
            end
        end
        total_beats = stim_beats.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        do @(posedge clk);
        while (!(beats_in == total_beats && expected_reports.size() == 0));
        repeat (2 * BANK_SIZE) @(posedge clk);

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
